// File: design/csmfe_pkg.sv
// Package for the clock set-mode field editor.
// Holds focus slot and key codes plus the calendar helper functions.
// No dependencies.
package csmfe_pkg;

  // Field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int FOCUS_W  = 3;
  localparam int KEY_W    = 3;

  // Field limits
  localparam logic [YEAR_W-1:0]   YEAR_MAX     = 14'd9999;
  localparam logic [YEAR_W-1:0]   YEAR_RESET   = 14'd1970;
  localparam logic [MONTH_W-1:0]  MONTH_LAST   = 4'd12;
  localparam logic [HOUR_W-1:0]   HOUR_LAST    = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_LAST  = 6'd59;

  // Focus slots
  localparam logic [FOCUS_W-1:0] FOCUS_YEAR   = 3'd0;
  localparam logic [FOCUS_W-1:0] FOCUS_MONTH  = 3'd1;
  localparam logic [FOCUS_W-1:0] FOCUS_DAY    = 3'd2;
  localparam logic [FOCUS_W-1:0] FOCUS_HOUR   = 3'd3;
  localparam logic [FOCUS_W-1:0] FOCUS_MINUTE = 3'd4;
  localparam logic [FOCUS_W-1:0] FOCUS_SAVE   = 3'd5;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_OK_SHORT = 3'd0;
  localparam logic [KEY_W-1:0] KEY_OK_LONG  = 3'd1;
  localparam logic [KEY_W-1:0] KEY_POWER    = 3'd2;
  localparam logic [KEY_W-1:0] KEY_LEFT     = 3'd3;
  localparam logic [KEY_W-1:0] KEY_RIGHT    = 3'd4;

  // Request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  // Gregorian leap year. year / 100 comes from a reciprocal multiply
  // (exact for all 14-bit years), the remainder from a shift-add back.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [27:0] prod;
    logic [7:0]  q;
    logic [14:0] back;
    prod = {14'd0, y} * 28'd5243;
    q    = prod[26:19];
    back = ({7'd0, q} << 6) + ({7'd0, q} << 5) + ({7'd0, q} << 2);
    return (y[1:0] == 2'b00) && ((back != {1'b0, y}) || (q[1:0] == 2'b00));
  endfunction

  // Days in month; months outside 1..12 count as 31 days
  function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] y,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = is_leap(y) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: design/clock_set_mode_field_editor.sv
// Top level of the clock set-mode field editor.
// Depends on csmfe_pkg for codes, widths and calendar functions.
//
// Usage: a calendar clock's set mode. Each transaction on the in_ channel
// is either a load (req_type 0: copy the current date and time into the
// edit fields, focus year) or a key event (ok short / left add 1,
// ok long / right subtract 1, power moves focus; power on the save slot
// commits and returns to year). Each input transaction
// yields exactly one out_ transaction holding the focus, the five edited
// fields and the commit flag as they stand after that item.
// The cfg_ channel writes min_year; it is always ready.
// Path: each accepted input passes the input register, then one pass of
// field-update logic into the output register, which holds the result.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the update of the edit state between the input and output registers.
// Reset (synchronous, rst_n low): fields return to 1970-01-01 00:00, focus
// year, min_year 1970, both pipeline registers empty.
// When the receiver stalls, the output register holds its transaction; one
// more item may wait in the input register, after which in_stall rises.
module clock_set_mode_field_editor
  import csmfe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [YEAR_W-1:0]   in_load_year,
  input  logic [MONTH_W-1:0]  in_load_month,
  input  logic [DAY_W-1:0]    in_load_day,
  input  logic [HOUR_W-1:0]   in_load_hour,
  input  logic [MINUTE_W-1:0] in_load_minute,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FOCUS_W-1:0]  out_focus,
  output logic [YEAR_W-1:0]   out_shown_year,
  output logic [MONTH_W-1:0]  out_shown_month,
  output logic [DAY_W-1:0]    out_shown_day,
  output logic [HOUR_W-1:0]   out_shown_hour,
  output logic [MINUTE_W-1:0] out_shown_minute,
  output logic                out_commit,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [YEAR_W-1:0]   cfg_min_year
);

  // input register
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_req_type_r;
  logic [KEY_W-1:0]    s1_key_r;
  logic [YEAR_W-1:0]   s1_year_r;
  logic [MONTH_W-1:0]  s1_month_r;
  logic [DAY_W-1:0]    s1_day_r;
  logic [HOUR_W-1:0]   s1_hour_r;
  logic [MINUTE_W-1:0] s1_minute_r;

  // edit state
  logic [YEAR_W-1:0]   min_year_r;
  logic [FOCUS_W-1:0]  focus_r, focus_nxt;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [MONTH_W-1:0]  month_r, month_nxt;
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [HOUR_W-1:0]   hour_r, hour_nxt;
  logic [MINUTE_W-1:0] minute_r, minute_nxt;
  logic                commit_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic                commit_r;

  logic                advance;
  logic                step_up, step_dn;

  // field step helpers
  logic [YEAR_W-1:0]   year_lo;
  logic [YEAR_W:0]     year_inc;
  logic [YEAR_W-1:0]   year_up, year_dn;
  logic [MONTH_W:0]    month_inc;
  logic [MONTH_W-1:0]  month_up, month_dn;
  logic [DAY_W-1:0]    day_len;
  logic [DAY_W:0]      day_inc;
  logic [DAY_W-1:0]    day_up, day_dn;
  logic [HOUR_W:0]     hour_inc;
  logic [HOUR_W-1:0]   hour_up, hour_dn;
  logic [MINUTE_W:0]   minute_inc;
  logic [MINUTE_W-1:0] minute_up, minute_dn;

  // handshake
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign cfg_ready = 1'b1;
  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  // year: saturate at min_year (itself capped at 9999) and 9999
  always_comb begin
    year_lo  = (min_year_r > YEAR_MAX) ? YEAR_MAX : min_year_r;
    year_inc = {1'b0, year_r} + 15'd1;
    if (year_inc < {1'b0, year_lo}) begin
      year_up = year_lo;
    end else if (year_inc > {1'b0, YEAR_MAX}) begin
      year_up = YEAR_MAX;
    end else begin
      year_up = year_inc[YEAR_W-1:0];
    end
    if ((year_r == '0) || ((year_r - 14'd1) < year_lo)) begin
      year_dn = year_lo;
    end else if ((year_r - 14'd1) > YEAR_MAX) begin
      year_dn = YEAR_MAX;
    end else begin
      year_dn = year_r - 14'd1;
    end
  end

  // month wraps 1..12
  always_comb begin
    month_inc = {1'b0, month_r} + 5'd1;
    month_up  = (month_inc > {1'b0, MONTH_LAST}) ? 4'd1 : month_inc[MONTH_W-1:0];
    if (month_r <= 4'd1) begin
      month_dn = MONTH_LAST;
    end else if ((month_r - 4'd1) > MONTH_LAST) begin
      month_dn = 4'd1;
    end else begin
      month_dn = month_r - 4'd1;
    end
  end

  // day wraps 1..month length
  always_comb begin
    day_len = month_len(year_r, month_r);
    day_inc = {1'b0, day_r} + 6'd1;
    day_up  = (day_inc > {1'b0, day_len}) ? 5'd1 : day_inc[DAY_W-1:0];
    if (day_r <= 5'd1) begin
      day_dn = day_len;
    end else if ((day_r - 5'd1) > day_len) begin
      day_dn = 5'd1;
    end else begin
      day_dn = day_r - 5'd1;
    end
  end

  // hour wraps 0..23, minute wraps 0..59
  always_comb begin
    hour_inc = {1'b0, hour_r} + 6'd1;
    hour_up  = (hour_inc > {1'b0, HOUR_LAST}) ? '0 : hour_inc[HOUR_W-1:0];
    if (hour_r == '0) begin
      hour_dn = HOUR_LAST;
    end else if ((hour_r - 5'd1) > HOUR_LAST) begin
      hour_dn = '0;
    end else begin
      hour_dn = hour_r - 5'd1;
    end
    minute_inc = {1'b0, minute_r} + 7'd1;
    minute_up  = (minute_inc > {1'b0, MINUTE_LAST}) ? '0 : minute_inc[MINUTE_W-1:0];
    if (minute_r == '0) begin
      minute_dn = MINUTE_LAST;
    end else if ((minute_r - 6'd1) > MINUTE_LAST) begin
      minute_dn = '0;
    end else begin
      minute_dn = minute_r - 6'd1;
    end
  end

  // key decode
  always_comb begin
    step_up = 1'b0;
    step_dn = 1'b0;
    unique case (s1_key_r)
      KEY_OK_SHORT, KEY_LEFT: step_up = 1'b1;
      KEY_OK_LONG, KEY_RIGHT: step_dn = 1'b1;
      default: ;
    endcase
  end

  // next edit state for the item in the input register
  always_comb begin
    focus_nxt  = focus_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    commit_nxt = 1'b0;
    if (s1_req_type_r == REQ_LOAD) begin
      focus_nxt  = FOCUS_YEAR;
      year_nxt   = s1_year_r;
      month_nxt  = s1_month_r;
      day_nxt    = s1_day_r;
      hour_nxt   = s1_hour_r;
      minute_nxt = s1_minute_r;
    end else if (s1_key_r == KEY_POWER) begin
      if (focus_r >= FOCUS_SAVE) begin
        focus_nxt  = FOCUS_YEAR;
        commit_nxt = 1'b1;
      end else begin
        focus_nxt = focus_r + 3'd1;
      end
    end else if (step_up || step_dn) begin
      unique case (focus_r)
        FOCUS_YEAR:   year_nxt   = step_up ? year_up   : year_dn;
        FOCUS_MONTH:  month_nxt  = step_up ? month_up  : month_dn;
        FOCUS_DAY:    day_nxt    = step_up ? day_up    : day_dn;
        FOCUS_HOUR:   hour_nxt   = step_up ? hour_up   : hour_dn;
        FOCUS_MINUTE: minute_nxt = step_up ? minute_up : minute_dn;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      min_year_r  <= YEAR_RESET;
      focus_r     <= FOCUS_YEAR;
      year_r      <= YEAR_RESET;
      month_r     <= 4'd1;
      day_r       <= 5'd1;
      hour_r      <= '0;
      minute_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        min_year_r <= cfg_min_year;
      end
      if (advance) begin
        focus_r  <= focus_nxt;
        year_r   <= year_nxt;
        month_r  <= month_nxt;
        day_r    <= day_nxt;
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_type_r <= in_req_type;
      s1_key_r      <= in_key;
      s1_year_r     <= in_load_year;
      s1_month_r    <= in_load_month;
      s1_day_r      <= in_load_day;
      s1_hour_r     <= in_load_hour;
      s1_minute_r   <= in_load_minute;
    end
  end

  // commit flag travels with the result
  always_ff @(posedge clk) begin
    if (advance) begin
      commit_r <= commit_nxt;
    end
  end

  // result fields show the edit state after the item
  assign out_valid        = out_valid_r;
  assign out_focus        = focus_r;
  assign out_shown_year   = year_r;
  assign out_shown_month  = month_r;
  assign out_shown_day    = day_r;
  assign out_shown_hour   = hour_r;
  assign out_shown_minute = minute_r;
  assign out_commit       = commit_r;

endmodule

// File: design/csmfe_checker.sv
// Port-level checker for the clock set-mode field editor, bound to the top.
// Depends on csmfe_pkg for the focus slot codes.
module csmfe_checker
  import csmfe_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [FOCUS_W-1:0]  out_focus,
  input logic [YEAR_W-1:0]   out_shown_year,
  input logic [MINUTE_W-1:0] out_shown_minute,
  input logic                out_commit
);

  // a commit always returns focus to year
  a_commit_focus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_commit |-> out_focus == FOCUS_YEAR)
    else $error("commit with focus not on year");

  // focus never leaves the six slots
  a_focus_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_focus <= FOCUS_SAVE)
    else $error("focus out of range");

  // input side only stalls when a result is held back by the receiver
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_focus) &&
      $stable(out_shown_year) && $stable(out_shown_minute) && $stable(out_commit))
    else $error("stalled result changed");

endmodule

bind clock_set_mode_field_editor csmfe_checker u_csmfe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_focus        (out_focus),
  .out_shown_year   (out_shown_year),
  .out_shown_minute (out_shown_minute),
  .out_commit       (out_commit)
);

// File: test/clock_set_mode_field_editor_tb.sv
// Testbench for clock_set_mode_field_editor: directed and random load and key
// transactions, each result checked field by field against an in-bench editor model.
// Depends on csmfe_pkg and the design top level only.
module clock_set_mode_field_editor_tb;
  import csmfe_pkg::*;

  localparam int STALL_PCT   = 19;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 215;
  localparam logic [KEY_W-1:0]  KEY_OTHER     = 3'd5;
  localparam logic [KEY_W-1:0]  KEY_TOP       = 3'd7;
  localparam logic [YEAR_W-1:0] YEAR_ALL_ONES = '1;

  typedef struct packed {
    logic                req_type;
    logic [KEY_W-1:0]    key;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } edit_req_t;

  typedef struct packed {
    logic [FOCUS_W-1:0]  focus;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic                commit_flag;
  } edit_view_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_req_type;
  logic [KEY_W-1:0]    in_key;
  logic [YEAR_W-1:0]   in_load_year;
  logic [MONTH_W-1:0]  in_load_month;
  logic [DAY_W-1:0]    in_load_day;
  logic [HOUR_W-1:0]   in_load_hour;
  logic [MINUTE_W-1:0] in_load_minute;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [FOCUS_W-1:0]  out_focus;
  logic [YEAR_W-1:0]   out_shown_year;
  logic [MONTH_W-1:0]  out_shown_month;
  logic [DAY_W-1:0]    out_shown_day;
  logic [HOUR_W-1:0]   out_shown_hour;
  logic [MINUTE_W-1:0] out_shown_minute;
  logic                out_commit;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [YEAR_W-1:0]   cfg_min_year;

  // Editor model state
  logic [YEAR_W-1:0]   ed_min_year;
  logic [FOCUS_W-1:0]  ed_focus;
  logic [YEAR_W-1:0]   ed_year;
  logic [MONTH_W-1:0]  ed_month;
  logic [DAY_W-1:0]    ed_day;
  logic [HOUR_W-1:0]   ed_hour;
  logic [MINUTE_W-1:0] ed_minute;

  edit_view_t pending_views[$];
  edit_view_t want_view;
  int  sent_count   = 0;
  int  failures     = 0;
  int  quiet_cycles = 0;
  bit  src_idle_on  = 1'b1;
  bit  sink_idle_on = 1'b1;
  int  hold_len     = 0;
  int  hold_seq     = 0;
  int  hold_seen    = 0;
  int  hold_left    = 0;
  int  leap_years[6] = '{1900, 2000, 2024, 2023, 2100, 2400};

  clock_set_mode_field_editor DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_key           (in_key),
    .in_load_year     (in_load_year),
    .in_load_month    (in_load_month),
    .in_load_day      (in_load_day),
    .in_load_hour     (in_load_hour),
    .in_load_minute   (in_load_minute),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_focus        (out_focus),
    .out_shown_year   (out_shown_year),
    .out_shown_month  (out_shown_month),
    .out_shown_day    (out_shown_day),
    .out_shown_hour   (out_shown_hour),
    .out_shown_minute (out_shown_minute),
    .out_commit       (out_commit),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_min_year     (cfg_min_year)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Editor model
  // ---------------------------------------------------------------------------

  // Gregorian month length; months outside 1..12 count as 31 days
  function automatic int days_in_month(int y, int m);
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m == 2) return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
    return 31;
  endfunction

  function automatic int wrap_field(int v, int lo, int hi);
    if (v < lo) return hi;
    if (v > hi) return lo;
    return v;
  endfunction

  // Add delta to the focused field; save slot is left alone
  function automatic void nudge_field(int delta);
    int v;
    int lo;
    case (ed_focus)
      FOCUS_YEAR: begin
        lo = (ed_min_year > YEAR_MAX) ? int'(YEAR_MAX) : int'(ed_min_year);
        v = int'(ed_year) + delta;
        if (v < lo) v = lo;
        if (v > int'(YEAR_MAX)) v = int'(YEAR_MAX);
        ed_year = YEAR_W'(v);
      end
      FOCUS_MONTH:
        ed_month = MONTH_W'(wrap_field(int'(ed_month) + delta, 1, int'(MONTH_LAST)));
      FOCUS_DAY:
        ed_day = DAY_W'(wrap_field(int'(ed_day) + delta, 1,
                                   days_in_month(int'(ed_year), int'(ed_month))));
      FOCUS_HOUR:
        ed_hour = HOUR_W'(wrap_field(int'(ed_hour) + delta, 0, int'(HOUR_LAST)));
      FOCUS_MINUTE:
        ed_minute = MINUTE_W'(wrap_field(int'(ed_minute) + delta, 0,
                                         int'(MINUTE_LAST)));
      default: ;
    endcase
  endfunction

  // Advance the model by one transaction and return the view it should show
  function automatic edit_view_t apply_item(edit_req_t r);
    edit_view_t v;
    logic       saved;
    saved = 1'b0;
    if (r.req_type == REQ_LOAD) begin
      ed_year   = r.year;
      ed_month  = r.month;
      ed_day    = r.day;
      ed_hour   = r.hour;
      ed_minute = r.minute;
      ed_focus  = FOCUS_YEAR;
    end else begin
      case (r.key)
        KEY_OK_SHORT, KEY_LEFT: nudge_field(1);
        KEY_OK_LONG, KEY_RIGHT: nudge_field(-1);
        KEY_POWER: begin
          if (ed_focus >= FOCUS_SAVE) begin
            ed_focus = FOCUS_YEAR;
            saved = 1'b1;
          end else begin
            ed_focus = ed_focus + 3'd1;
          end
        end
        default: ;
      endcase
    end
    v.focus       = ed_focus;
    v.year        = ed_year;
    v.month       = ed_month;
    v.day         = ed_day;
    v.hour        = ed_hour;
    v.minute      = ed_minute;
    v.commit_flag = saved;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Transaction helpers
  // ---------------------------------------------------------------------------

  // Key event; the load fields carry random noise
  function automatic edit_req_t key_req(logic [KEY_W-1:0] k);
    edit_req_t r;
    r          = edit_req_t'({$urandom, $urandom});
    r.req_type = REQ_KEY;
    r.key      = k;
    return r;
  endfunction

  // Load of the given date; the key field carries random noise
  function automatic edit_req_t load_req(int y, int m, int d, int h, int mi);
    edit_req_t r;
    r.req_type = REQ_LOAD;
    r.key      = KEY_W'($urandom);
    r.year     = YEAR_W'(y);
    r.month    = MONTH_W'(m);
    r.day      = DAY_W'(d);
    r.hour     = HOUR_W'(h);
    r.minute   = MINUTE_W'(mi);
    return r;
  endfunction

  task automatic send_item(edit_req_t r);
    @(negedge clk);
    while (src_idle_on && $urandom_range(99) < STALL_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_req_type    = r.req_type;
    in_key         = r.key;
    in_load_year   = r.year;
    in_load_month  = r.month;
    in_load_day    = r.day;
    in_load_hour   = r.hour;
    in_load_minute = r.minute;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_views.push_back(apply_item(r));
    sent_count++;
  endtask

  // Stop offering and wait until every expected view has been returned
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic set_min_year(logic [YEAR_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid    = 1'b1;
    cfg_min_year = v;
    do @(posedge clk); while (!cfg_ready);
    ed_min_year = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Year biased toward the saturation points, the floor and leap-year corners
  function automatic logic [YEAR_W-1:0] pick_year();
    int base;
    base = (ed_min_year > YEAR_MAX) ? int'(YEAR_MAX) : int'(ed_min_year);
    case ($urandom_range(9))
      0:       return YEAR_MAX - YEAR_W'($urandom_range(2));
      1:       return YEAR_W'(base + $urandom_range(2));
      2, 3:    return YEAR_W'(leap_years[$urandom_range(5)]);
      4:       return YEAR_W'($urandom);
      5:       return '0;
      default: return YEAR_W'($urandom_range(2100, 1970));
    endcase
  endfunction

  function automatic edit_req_t random_date_load();
    int y;
    int m;
    int d;
    int h;
    int mi;
    int len;
    y   = pick_year();
    m   = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
    len = days_in_month(y, m);
    case ($urandom_range(5))
      0:       d = 1;
      1:       d = len;
      2:       d = $urandom_range(31, 28);
      3:       d = $urandom_range(31);
      default: d = $urandom_range(len, 1);
    endcase
    case ($urandom_range(9))
      0:       h = $urandom_range(31);
      1:       h = $urandom_range(1) ? HOUR_LAST : 0;
      default: h = $urandom_range(HOUR_LAST);
    endcase
    case ($urandom_range(9))
      0:       mi = $urandom_range(63);
      1:       mi = $urandom_range(1) ? MINUTE_LAST : 0;
      default: mi = $urandom_range(MINUTE_LAST);
    endcase
    return load_req(y, m, d, h, mi);
  endfunction

  // One editing session: usually a load followed by a walk of key presses
  task automatic random_session();
    int               pick;
    int               run;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(99);
    if (pick < 85) begin
      send_item(random_date_load());
    end else if (pick < 92) begin
      send_item(load_req($urandom, $urandom, $urandom, $urandom, $urandom));
    end
    // otherwise keys carry on from wherever the editor stands
    repeat ($urandom_range(30, 4)) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_item(key_req(KEY_POWER));
      end else if (pick < 90) begin
        case ($urandom_range(3))
          0:       k = KEY_OK_SHORT;
          1:       k = KEY_LEFT;
          2:       k = KEY_OK_LONG;
          default: k = KEY_RIGHT;
        endcase
        run = $urandom_range(8, 1);
        repeat (run) send_item(key_req(k));
      end else begin
        send_item(key_req(KEY_W'($urandom_range(KEY_TOP, KEY_OTHER))));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk month, day, hour and minute through both wrap points, saturate year, save slot and commit
  task automatic test_field_edits();
    send_item(key_req(KEY_TOP));               // ignored key shows reset values
    send_item(load_req(YEAR_MAX, MONTH_LAST, 31, HOUR_LAST, MINUTE_LAST));
    send_item(key_req(KEY_OK_SHORT));          // year saturates at 9999
    send_item(key_req(KEY_POWER));
    send_item(key_req(KEY_LEFT));              // month 12 -> 1
    send_item(key_req(KEY_RIGHT));             // month 1 -> 12
    send_item(key_req(KEY_POWER));
    send_item(key_req(KEY_OK_SHORT));          // day 31 -> 1
    send_item(key_req(KEY_OK_LONG));           // day 1 -> 31
    send_item(key_req(KEY_POWER));
    send_item(key_req(KEY_LEFT));              // hour 23 -> 0
    send_item(key_req(KEY_RIGHT));             // hour 0 -> 23
    send_item(key_req(KEY_POWER));
    send_item(key_req(KEY_OK_SHORT));          // minute 59 -> 0
    send_item(key_req(KEY_OK_LONG));           // minute 0 -> 59
    send_item(key_req(KEY_POWER));
    send_item(key_req(KEY_OK_SHORT));          // adjust on save does nothing
    send_item(key_req(KEY_RIGHT));
    send_item(key_req(KEY_OTHER));
    send_item(key_req(KEY_POWER));             // commit, back to year
    // out-of-range load, then edits pull fields back in
    send_item(load_req(YEAR_ALL_ONES, 15, 0, 31, 63));
    send_item(key_req(KEY_OK_LONG));           // year capped at 9999
    send_item(key_req(KEY_POWER));
    send_item(key_req(KEY_POWER));
    send_item(key_req(KEY_OK_LONG));           // day 0 in bad month -> 31
    // leap day in a year divisible by 400
    send_item(load_req(2000, 2, 29, 12, 30));
    send_item(key_req(KEY_POWER));
    send_item(key_req(KEY_POWER));
    send_item(key_req(KEY_OK_SHORT));          // 29 -> 1
  endtask

  // Year floor at its extremes, including one above the year ceiling
  task automatic test_min_year_limits();
    set_min_year(YEAR_MAX);
    send_item(load_req(2000, 6, 15, 8, 20));
    send_item(key_req(KEY_OK_SHORT));
    set_min_year(YEAR_ALL_ONES);
    send_item(load_req(5000, 6, 15, 8, 20));
    send_item(key_req(KEY_OK_LONG));
    set_min_year('0);
    send_item(load_req(0, 1, 1, 0, 0));
    send_item(key_req(KEY_RIGHT));
    set_min_year(YEAR_RESET);
    send_item(load_req(YEAR_RESET, 1, 1, 0, 0));
    send_item(key_req(KEY_OK_LONG));
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_back_pressure();
    wait_drained();
    src_idle_on = 1'b0;
    hold_len    = HOLD_CYCLES;
    hold_seq++;
    send_item(random_date_load());
    repeat (5) send_item(key_req(KEY_LEFT));
    repeat (5) send_item(key_req(KEY_POWER));
    repeat (5) send_item(key_req(KEY_RIGHT));
    wait_drained();
    src_idle_on = 1'b1;
  endtask

  // Random sessions under several year floors; one phase runs without idling
  task automatic test_random_traffic();
    logic [YEAR_W-1:0] floors[5] = '{YEAR_RESET, '0, YEAR_MAX, YEAR_ALL_ONES, 14'd2000};
    int                stop_at;
    for (int phase = 0; phase < 6; phase++) begin
      set_min_year((phase < 5) ? floors[phase] : YEAR_W'($urandom));
      src_idle_on  = (phase != 2);
      sink_idle_on = (phase != 2);
      stop_at = sent_count + PHASE_ITEMS;
      while (sent_count < stop_at) random_session();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Result side stall: random idling plus requested long holds
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = sink_idle_on && ($urandom_range(99) < STALL_PCT);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  // Compare each returned transaction with the oldest expected view
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        $error("result transaction with no expected view pending");
        failures++;
      end else begin
        want_view = pending_views.pop_front();
        check_field("focus", want_view.focus, out_focus);
        check_field("shown_year", want_view.year, out_shown_year);
        check_field("shown_month", want_view.month, out_shown_month);
        check_field("shown_day", want_view.day, out_shown_day);
        check_field("shown_hour", want_view.hour, out_shown_hour);
        check_field("shown_minute", want_view.minute, out_shown_minute);
        check_field("commit", want_view.commit_flag, out_commit);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transaction for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_LOAD;
    in_key         = KEY_OK_SHORT;
    in_load_year   = '0;
    in_load_month  = '0;
    in_load_day    = '0;
    in_load_hour   = '0;
    in_load_minute = '0;
    cfg_valid      = 1'b0;
    cfg_min_year   = '0;
    // model starts from the reset values
    ed_min_year = YEAR_RESET;
    ed_focus    = FOCUS_YEAR;
    ed_year     = YEAR_RESET;
    ed_month    = 4'd1;
    ed_day      = 5'd1;
    ed_hour     = '0;
    ed_minute   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_edits();
    test_min_year_limits();
    test_back_pressure();
    test_random_traffic();

    // drain, then allow the pipeline latency for any stray result
    wait_drained();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
